FILE: sv/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the sorted list merge block.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int DATA_W         = 32;

  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_SECOND = 2'd1,
    MODE_MERGE  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic                     from_second;
    logic                     last_of_run;
    logic                     items_dropped;
  } out_beat_t;

  typedef struct packed {
    logic a_avail;
    logic b_avail;
  } avail_t;

endpackage

FILE: sv/slm_ram.sv
// ----------------------------------------------------------------------------
// slm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/slm_pick.sv
// ----------------------------------------------------------------------------
// slm_pick
// Shared compare unit: selects the smaller head, first list on ties.
// ----------------------------------------------------------------------------
module slm_pick
  import slm_pkg::*;
(
  input  logic signed [DATA_W-1:0] a_data,
  input  logic signed [DATA_W-1:0] b_data,
  input  avail_t                   avail,
  output logic                     take_second,
  output logic signed [DATA_W-1:0] pick_value
);

  always_comb begin
    take_second = avail.b_avail && (!avail.a_avail || (a_data > b_data));
    pick_value  = take_second ? b_data : a_data;
  end

endmodule

FILE: sv/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer: loads both lists, walks the merge and holds the output register.
// ----------------------------------------------------------------------------
module slm_ctrl
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_beat_t                out_data,
  output logic                     we_a,
  output logic                     we_b,
  output logic [AW-1:0]            wr_addr_a,
  output logic [AW-1:0]            wr_addr_b,
  output logic [AW-1:0]            rd_addr_a,
  output logic [AW-1:0]            rd_addr_b,
  output avail_t                   avail,
  input  logic                     take_second,
  input  logic signed [DATA_W-1:0] pick_value
);

  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] cnt_a, cnt_a_next, cnt_b, cnt_b_next;
  logic [CW-1:0] idx_a, idx_a_next, idx_b, idx_b_next;
  logic          overflow, overflow_next;
  logic          out_valid_next;
  out_beat_t     out_data_next;
  logic          accept, load_out, last;

  assign accept    = in_valid && in_ready;
  assign wr_addr_a = cnt_a[AW-1:0];
  assign wr_addr_b = cnt_b[AW-1:0];
  assign rd_addr_a = idx_a[AW-1:0];
  assign rd_addr_b = idx_b[AW-1:0];
  assign avail.a_avail = idx_a < cnt_a;
  assign avail.b_avail = idx_b < cnt_b;
  assign last = ({1'b0, idx_a} + {1'b0, idx_b} + (CW+1)'(1)) == ({1'b0, cnt_a} + {1'b0, cnt_b});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      idx_a     <= '0;
      idx_b     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt_a     <= cnt_a_next;
      cnt_b     <= cnt_b_next;
      idx_a     <= idx_a_next;
      idx_b     <= idx_b_next;
      overflow  <= overflow_next;
      out_valid <= out_valid_next;
    end
    out_data <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    cnt_a_next     = cnt_a;
    cnt_b_next     = cnt_b;
    idx_a_next     = idx_a;
    idx_b_next     = idx_b;
    overflow_next  = overflow;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    in_ready       = 1'b0;
    we_a           = 1'b0;
    we_b           = 1'b0;
    load_out       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_data.mode)
            MODE_FIRST: begin
              if (cnt_a < DEPTH_C) begin
                we_a       = 1'b1;
                cnt_a_next = cnt_a + CW'(1);
              end else begin
                overflow_next = 1'b1;
              end
            end
            MODE_SECOND: begin
              if (cnt_b < DEPTH_C) begin
                we_b       = 1'b1;
                cnt_b_next = cnt_b + CW'(1);
              end else begin
                overflow_next = 1'b1;
              end
            end
            MODE_MERGE: begin
              idx_a_next = '0;
              idx_b_next = '0;
              if (cnt_a == '0 && cnt_b == '0) begin
                overflow_next = 1'b0;
              end else begin
                state_next = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!out_valid || out_ready) begin
          load_out                    = 1'b1;
          out_valid_next              = 1'b1;
          out_data_next.merged_value  = pick_value;
          out_data_next.from_second   = take_second;
          out_data_next.last_of_run   = last;
          out_data_next.items_dropped = overflow;
          if (take_second) begin
            idx_b_next = idx_b + CW'(1);
          end else begin
            idx_a_next = idx_a + CW'(1);
          end
          if (last) begin
            cnt_a_next    = '0;
            cnt_b_next    = '0;
            overflow_next = 1'b0;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (!load_out && state != ST_CMP) begin
      out_data_next = out_data;
    end
  end

endmodule

FILE: sv/sorted_list_merge.sv
// ----------------------------------------------------------------------------
// sorted_list_merge
// Two-way stable merge of two ascending lists of signed values.
// ----------------------------------------------------------------------------
// Input beats carry a mode and a value. Mode first or second appends the
// value to that list; a beat into a full list is dropped and sets a
// sticky drop flag. Mode merge streams every stored value out in
// ascending signed order, first list first on ties, with the last beat of
// the run marked and the drop flag repeated on each beat.
// Each merged beat passes through a read step, for the registered RAM reads
// of both list heads, and a compare step, in which the shared compare unit
// loads the output register. After the merge beat is accepted, the first
// result takes the read step and then the compare step into that register.
// in_ready is low from the merge beat until the last result is loaded.
// If the receiver stalls, the output register holds and the sequencer waits
// in its compare step. After the merge both counts and the drop flag clear.
// Reset clears the counts, the flag, the sequencer and out_valid; the list
// RAMs are not cleared, since only entries below a count are read.
// ----------------------------------------------------------------------------
module sorted_list_merge
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                     we_a, we_b, take_second;
  logic [AW-1:0]            wr_addr_a, wr_addr_b, rd_addr_a, rd_addr_b;
  logic signed [DATA_W-1:0] a_data, b_data, pick_value;
  avail_t                   avail;

  slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_a (
    .clk     (clk),
    .we      (we_a),
    .wr_addr (wr_addr_a),
    .wr_data (in_data.item_value),
    .rd_addr (rd_addr_a),
    .rd_data (a_data)
  );

  slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH), .AW(AW)) u_ram_b (
    .clk     (clk),
    .we      (we_b),
    .wr_addr (wr_addr_b),
    .wr_data (in_data.item_value),
    .rd_addr (rd_addr_b),
    .rd_data (b_data)
  );

  slm_pick u_pick (
    .a_data      (a_data),
    .b_data      (b_data),
    .avail       (avail),
    .take_second (take_second),
    .pick_value  (pick_value)
  );

  slm_ctrl #(.LIST_DEPTH(LIST_DEPTH), .AW(AW)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .we_a        (we_a),
    .we_b        (we_b),
    .wr_addr_a   (wr_addr_a),
    .wr_addr_b   (wr_addr_b),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .avail       (avail),
    .take_second (take_second),
    .pick_value  (pick_value)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-way sorted list merge.
// ----------------------------------------------------------------------------
// Loads both lists through the input channel and tracks their contents, the
// counts and the sticky drop flag. Every merge beat turns the two lists into
// the expected stream of merged beats, which the output monitor compares
// field by field. The directed tests cover value extremes, ties, an unused
// mode, empty and one-sided merges, and overflow of both lists. A
// back-pressure test holds the output off while appends queue up behind a
// merge. The random test loads sorted lists with random content, adds some
// noise, and merges. The sender idles in random bursts and the receiver
// stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
  import slm_pkg::*;

  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RANDOM_ITEMS   = 32;
  localparam int          HOLD_CYCLES    = 300;
  localparam logic [31:0] INT_MIN        = 32'h8000_0000;
  localparam logic [31:0] INT_MAX        = 32'h7FFF_FFFF;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  logic signed [DATA_W-1:0] first_vals[$];
  logic signed [DATA_W-1:0] second_vals[$];
  logic                     drop_flag = 1'b0;
  out_beat_t                pending_merged[$];

  int        error_count = 0;
  int        items_sent;
  int        burst_left;
  int        hold_req;
  int        hold_done;
  int        hold_left;
  int        idle_cycles;
  logic [15:0] stall_pattern;
  int        pattern_age;

  sorted_list_merge i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    error_count++;
    if (error_count <= 50)
      $display("mismatch on %s: got %h, want %h at %0t", field, got, want, $realtime);
  endtask

  // Update the list state for one accepted input beat and queue merged beats.
  task track_input_beat(input in_beat_t b);
    int        i;
    int        j;
    int        total;
    out_beat_t o;
    i = 0;
    j = 0;
    case (b.mode)
      MODE_FIRST: begin
        if (first_vals.size() < LIST_DEPTH_DEF) first_vals = {first_vals, b.item_value};
        else drop_flag = 1'b1;
      end
      MODE_SECOND: begin
        if (second_vals.size() < LIST_DEPTH_DEF) second_vals = {second_vals, b.item_value};
        else drop_flag = 1'b1;
      end
      MODE_MERGE: begin
        total = first_vals.size() + second_vals.size();
        for (int n = 0; n < total; n++) begin
          if (i < first_vals.size() &&
              (j >= second_vals.size() || first_vals[i] <= second_vals[j])) begin
            o.merged_value = first_vals[i];
            o.from_second  = 1'b0;
            i++;
          end else begin
            o.merged_value = second_vals[j];
            o.from_second  = 1'b1;
            j++;
          end
          o.last_of_run   = (n + 1 == total);
          o.items_dropped = drop_flag;
          pending_merged  = {pending_merged, o};
        end
        first_vals.delete();
        second_vals.delete();
        drop_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) track_input_beat(in_data);
      if (out_valid && out_ready) begin
        if (pending_merged.size() == 0) begin
          report_mismatch("unexpected beat", out_data.merged_value, '0);
        end else begin
          want = pending_merged.pop_front();
          if (out_data.merged_value !== want.merged_value)
            report_mismatch("merged_value", out_data.merged_value, want.merged_value);
          if (out_data.from_second !== want.from_second)
            report_mismatch("from_second", 32'(out_data.from_second),
                            32'(want.from_second));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(out_data.last_of_run),
                            32'(want.last_of_run));
          if (out_data.items_dropped !== want.items_dropped)
            report_mismatch("items_dropped", 32'(out_data.items_dropped),
                            32'(want.items_dropped));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Hold off for a requested stretch, else follow a rotating stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_ready     <= 1'b0;
      stall_pattern = 16'hFFFF;
      pattern_age   = 0;
      hold_done     = 0;
      hold_left     = 0;
    end else begin
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        if (pattern_age == 0) begin
          case ($urandom_range(0, 2))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'($urandom() | $urandom());
            default: stall_pattern = 16'($urandom()) | 16'h8001;
          endcase
        end
        pattern_age = (pattern_age + 1) % 64;
        out_ready <= stall_pattern[pattern_age % 16];
      end
    end
  end

  task send_beat(input logic [1:0] m, input logic [31:0] v);
    in_beat_t b;
    int       gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    b.mode       = m;
    b.item_value = v;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task test_extremes;
    send_beat(MODE_FIRST, INT_MIN);
    send_beat(MODE_SECOND, INT_MIN);
    send_beat(MODE_FIRST, 32'hFFFF_FFFF);
    send_beat(MODE_SECOND, 32'd0);
    send_beat(MODE_UNUSED, 32'h5A5A_A5A5);
    send_beat(MODE_FIRST, 32'd0);
    send_beat(MODE_SECOND, 32'd0);
    send_beat(MODE_SECOND, 32'd1);
    send_beat(MODE_FIRST, INT_MAX);
    send_beat(MODE_SECOND, INT_MAX);
    send_beat(MODE_MERGE, 32'hA5A5_5A5A);
  endtask

  task test_empty_and_one_sided;
    send_beat(MODE_MERGE, 32'd0);
    send_beat(MODE_FIRST, 32'hFFFF_FF00);
    send_beat(MODE_FIRST, 32'h0000_00FF);
    send_beat(MODE_MERGE, 32'd0);
    send_beat(MODE_SECOND, INT_MIN);
    send_beat(MODE_SECOND, INT_MAX);
    send_beat(MODE_MERGE, 32'd0);
    send_beat(MODE_UNUSED, 32'd0);
    send_beat(MODE_MERGE, 32'hFFFF_FFFF);
  endtask

  task test_full_lists;
    for (int k = 0; k < LIST_DEPTH_DEF + 2; k++) send_beat(MODE_FIRST, 3 * k - 50);
    for (int k = 0; k < LIST_DEPTH_DEF + 1; k++) send_beat(MODE_SECOND, 2 * k - 40);
    send_beat(MODE_MERGE, 32'd0);
    send_beat(MODE_SECOND, 32'd7);
    send_beat(MODE_MERGE, 32'd0);
  endtask

  task test_back_pressure;
    for (int k = 0; k < 12; k++) begin
      send_beat(MODE_FIRST, $urandom_range(0, 100) + 200 * k);
      send_beat(MODE_SECOND, $urandom_range(0, 100) + 200 * k);
    end
    hold_req++;
    send_beat(MODE_MERGE, 32'd0);
    for (int k = 0; k < 4; k++) send_beat(MODE_FIRST, 10 * k);
    send_beat(MODE_MERGE, 32'd0);
  endtask

  task test_random_lists;
    logic signed [31:0] first_q[$];
    logic signed [31:0] second_q[$];
    logic signed [31:0] v;
    int                 n_first;
    int                 n_second;
    int                 style;
    int                 pos;
    int                 stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) begin
        n_first  = $urandom_range(LIST_DEPTH_DEF - 1, LIST_DEPTH_DEF + 2);
        n_second = $urandom_range(LIST_DEPTH_DEF - 1, LIST_DEPTH_DEF + 2);
      end else begin
        n_first  = $urandom_range(0, 6);
        n_second = $urandom_range(0, 6);
      end
      style = $urandom_range(0, 2);
      for (int k = 0; k < n_first + n_second; k++) begin
        case (style)
          0: v = $urandom();
          1: v = $signed($urandom_range(0, 6)) - 3;
          default: begin
            case ($urandom_range(0, 4))
              0:       v = INT_MIN;
              1:       v = INT_MAX;
              2:       v = -1;
              3:       v = 0;
              default: v = $urandom();
            endcase
          end
        endcase
        pos = 0;
        if (k < n_first) begin
          while (pos < first_q.size() && first_q[pos] <= v) pos++;
          first_q.insert(pos, v);
        end else begin
          while (pos < second_q.size() && second_q[pos] <= v) pos++;
          second_q.insert(pos, v);
        end
      end
      while (first_q.size() + second_q.size() > 0) begin
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1) == 0) send_beat(MODE_UNUSED, $urandom());
          else send_beat(2'($urandom_range(0, 1)), $urandom());
        end
        if (second_q.size() == 0 || (first_q.size() > 0 && $urandom_range(0, 1) == 0))
          send_beat(MODE_FIRST, first_q.pop_front());
        else
          send_beat(MODE_SECOND, second_q.pop_front());
      end
      send_beat(MODE_MERGE, $urandom());
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    items_sent    = 0;
    burst_left    = 0;
    hold_req      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_empty_and_one_sided();
    test_full_lists();
    test_back_pressure();
    test_random_lists();
    send_beat(MODE_MERGE, 32'd0);
    in_valid <= 1'b0;
    while (pending_merged.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_merged.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/slm_pkg.sv
sv/slm_ram.sv
sv/slm_pick.sv
sv/slm_ctrl.sv
sv/sorted_list_merge.sv
tb/testbench.sv
